// ----- src/tvpl_pkg.sv -----
// Package for the thruster valve and pressure lag block.
// Holds the fixed-point constants, register indices and the shared structs.
// No dependencies.
package tvpl_pkg;

    // Field widths
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned CFG24_W = 24;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned Q_W     = 16;
    localparam int unsigned ADDR_W  = 3;

    // Q1.15 unity and unity gain in units of 2^-24
    localparam logic [Q_W-1:0] Q_ONE    = 16'h8000;
    localparam logic [24:0]    GAIN_ONE = 25'h100_0000;

    // Configuration register indices
    typedef enum logic [ADDR_W-1:0] {
        REG_IGN_DELAY  = 3'd0,
        REG_SHUT_DELAY = 3'd1,
        REG_MIN_ON     = 3'd2,
        REG_VALVE_RATE = 3'd3,
        REG_PRESS_RATE = 3'd4,
        REG_THRUST     = 3'd5,
        REG_FLOW       = 3'd6
    } reg_idx_t;

    // Configuration register contents
    typedef struct packed {
        logic [CFG24_W-1:0] ignition_delay_us;
        logic [CFG24_W-1:0] shutdown_delay_us;
        logic [CFG24_W-1:0] min_on_time_us;
        logic [CFG24_W-1:0] valve_rate;
        logic [CFG24_W-1:0] pressure_rate;
        logic [WORD_W-1:0]  thrust_full;
        logic [WORD_W-1:0]  flow_per_thrust;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic [WORD_W-1:0] thrust;
        logic [WORD_W-1:0] prop_flow;
        logic              firing;
        logic [Q_W-1:0]    valve_out;
        logic [Q_W-1:0]    pressure_out;
    } res_t;

endpackage

// ----- src/tvpl_if.sv -----
// Handshake channels of the thruster valve and pressure lag block.
// Depends on tvpl_pkg for widths.
interface tvpl_item_if;
    import tvpl_pkg::*;
    logic              valid;
    logic              ready;
    logic              fire_cmd;
    logic [STEP_W-1:0] step_us;
    modport source (output valid, fire_cmd, step_us, input ready);
    modport sink   (input valid, fire_cmd, step_us, output ready);
endinterface

interface tvpl_result_if;
    import tvpl_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] thrust;
    logic [WORD_W-1:0] prop_flow;
    logic              firing;
    logic [Q_W-1:0]    valve_out;
    logic [Q_W-1:0]    pressure_out;
    modport source (output valid, thrust, prop_flow, firing, valve_out, pressure_out,
                    input ready);
    modport sink   (input valid, thrust, prop_flow, firing, valve_out, pressure_out,
                    output ready);
endinterface

interface tvpl_cfg_if;
    import tvpl_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- src/tvpl_cfg.sv -----
// Configuration register file of the thruster lag block.
// Depends on tvpl_pkg and the tvpl_cfg_if channel.
module tvpl_cfg (
    input  logic            clk,
    input  logic            rst_n,
    tvpl_cfg_if.sink        cfg,
    output tvpl_pkg::cfg_t  regs
);
    import tvpl_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    // Writes always taken
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the write word; unknown indices are dropped
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.addr)
                REG_IGN_DELAY:  regs_next.ignition_delay_us = cfg.data[CFG24_W-1:0];
                REG_SHUT_DELAY: regs_next.shutdown_delay_us = cfg.data[CFG24_W-1:0];
                REG_MIN_ON:     regs_next.min_on_time_us    = cfg.data[CFG24_W-1:0];
                REG_VALVE_RATE: regs_next.valve_rate        = cfg.data[CFG24_W-1:0];
                REG_PRESS_RATE: regs_next.pressure_rate     = cfg.data[CFG24_W-1:0];
                REG_THRUST:     regs_next.thrust_full       = cfg.data;
                REG_FLOW:       regs_next.flow_per_thrust   = cfg.data;
                default:        regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            regs_reg <= '0;
        else
            regs_reg <= regs_next;
    end

endmodule

// ----- src/tvpl_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
// No dependencies beyond tvpl_pkg widths.
module tvpl_mul (
    input  logic                          clk,
    input  logic [tvpl_pkg::WORD_W-1:0]   a,
    input  logic [tvpl_pkg::WORD_W-1:0]   b,
    output logic [2*tvpl_pkg::WORD_W-1:0] prod
);
    import tvpl_pkg::*;

    logic [2*WORD_W-1:0] prod_reg;

    // Product register, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ----- src/tvpl_ctrl.sv -----
// Sequencer and state of the thruster lag block: timers, firing flag, the two
// lags and the thrust and flow products, all through one shared multiplier.
// Depends on tvpl_pkg, tvpl_item_if and tvpl_mul.
module tvpl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    tvpl_item_if.sink       item,
    input  tvpl_pkg::cfg_t  regs,
    input  logic            out_free,
    output logic            res_load,
    output tvpl_pkg::res_t  res
);
    import tvpl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TIMER,
        S_VMUL,
        S_VUPD,
        S_PMUL,
        S_PUPD,
        S_TMUL,
        S_FMUL,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               cmd_reg, cmd_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [WORD_W-1:0]  on_reg, on_next;
    logic [WORD_W-1:0]  off_reg, off_next;
    logic               flag_reg, flag_next;
    logic [Q_W-1:0]     valve_reg, valve_next;
    logic [Q_W-1:0]     press_reg, press_next;
    logic               up_reg, up_next;
    logic [WORD_W-1:0]  thrust_reg, thrust_next;

    logic [WORD_W-1:0]   mul_a, mul_b;
    logic [2*WORD_W-1:0] prod;

    logic [WORD_W-1:0]  tsel;
    logic [WORD_W:0]    tsum;
    logic [WORD_W-1:0]  tsat;
    logic [WORD_W-1:0]  on_t, off_t;
    logic               flag_t;
    logic [24:0]        gain;
    logic [Q_W-1:0]     vtarget;
    logic               vup, pup;
    logic [Q_W-1:0]     vdiff, pdiff;
    logic [48:0]        trnd;
    logic [WORD_W-1:0]  thrust_sat;
    logic [2*WORD_W-1:0] frnd;

    tvpl_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Lag update: x +/- round(diff * gain / 2^24), clamped to [0, 1]
    function automatic logic [Q_W-1:0] lag_next(input logic [Q_W-1:0] x,
                                                 input logic up,
                                                 input logic [2*WORD_W-1:0] p);
        logic [40:0] r;
        logic [16:0] mag;
        logic [17:0] s;
        r   = p[40:0] + {17'd0, 24'h80_0000};
        mag = r[40:24];
        if (up)
            s = {2'b00, x} + {1'b0, mag};
        else
            s = {2'b00, x} - {1'b0, mag};
        if (s[17])
            lag_next = '0;
        else if (s > {2'b00, Q_ONE})
            lag_next = Q_ONE;
        else
            lag_next = s[Q_W-1:0];
    endfunction

    // Timers: one saturating add on whichever timer runs
    assign tsel = cmd_reg ? on_reg : off_reg;
    assign tsum = {1'b0, tsel} + {{(WORD_W+1-STEP_W){1'b0}}, step_reg};
    assign tsat = tsum[WORD_W] ? '1 : tsum[WORD_W-1:0];

    // Firing flag rules on the updated timers
    always_comb
    begin
        if (cmd_reg)
        begin
            on_t   = tsat;
            off_t  = '0;
            flag_t = flag_reg | (tsat > {8'd0, regs.ignition_delay_us});
        end
        else
        begin
            on_t   = '0;
            off_t  = tsat;
            flag_t = flag_reg & !(tsat > {8'd0, regs.shutdown_delay_us});
        end
        if (!flag_t && (on_t != '0) && (on_t < {8'd0, regs.min_on_time_us}))
            flag_t = 1'b1;
    end

    // Gain from the previous product, saturated at one
    assign gain = (prod[39:0] > {15'd0, GAIN_ONE}) ? GAIN_ONE : prod[24:0];

    // Lag differences and directions
    assign vtarget = flag_reg ? Q_ONE : '0;
    assign vup     = vtarget >= valve_reg;
    assign vdiff   = vup ? (vtarget - valve_reg) : (valve_reg - vtarget);
    assign pup     = valve_reg >= press_reg;
    assign pdiff   = pup ? (valve_reg - press_reg) : (press_reg - valve_reg);

    // Thrust rounding and saturation, flow rounding
    assign trnd       = {1'b0, prod[47:0]} + 49'h4000;
    assign thrust_sat = (|trnd[48:47]) ? '1 : trnd[46:15];
    assign frnd       = prod + 64'h8000_0000;

    // Multiplier operand selection
    always_comb
    begin
        case (state_reg)
            S_TIMER:
            begin
                mul_a = {16'd0, step_reg};
                mul_b = {8'd0, regs.valve_rate};
            end
            S_VMUL:
            begin
                mul_a = {16'd0, vdiff};
                mul_b = {7'd0, gain};
            end
            S_VUPD:
            begin
                mul_a = {16'd0, step_reg};
                mul_b = {8'd0, regs.pressure_rate};
            end
            S_PMUL:
            begin
                mul_a = {16'd0, pdiff};
                mul_b = {7'd0, gain};
            end
            S_TMUL:
            begin
                mul_a = {16'd0, press_reg};
                mul_b = regs.thrust_full;
            end
            S_FMUL:
            begin
                mul_a = thrust_sat;
                mul_b = regs.flow_per_thrust;
            end
            // keep the flow product steady while the result waits
            S_DONE:
            begin
                mul_a = thrust_reg;
                mul_b = regs.flow_per_thrust;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        step_next   = step_reg;
        on_next     = on_reg;
        off_next    = off_reg;
        flag_next   = flag_reg;
        valve_next  = valve_reg;
        press_next  = press_reg;
        up_next     = up_reg;
        thrust_next = thrust_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    cmd_next   = item.fire_cmd;
                    step_next  = item.step_us;
                    state_next = S_TIMER;
                end
            end
            S_TIMER:
            begin
                on_next    = on_t;
                off_next   = off_t;
                flag_next  = flag_t;
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                up_next    = vup;
                state_next = S_VUPD;
            end
            S_VUPD:
            begin
                valve_next = lag_next(valve_reg, up_reg, prod);
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                up_next    = pup;
                state_next = S_PUPD;
            end
            S_PUPD:
            begin
                press_next = lag_next(press_reg, up_reg, prod);
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                thrust_next = thrust_sat;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= 1'b0;
            step_reg   <= '0;
            on_reg     <= '0;
            off_reg    <= '0;
            flag_reg   <= 1'b0;
            valve_reg  <= '0;
            press_reg  <= '0;
            up_reg     <= 1'b0;
            thrust_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            step_reg   <= step_next;
            on_reg     <= on_next;
            off_reg    <= off_next;
            flag_reg   <= flag_next;
            valve_reg  <= valve_next;
            press_reg  <= press_next;
            up_reg     <= up_next;
            thrust_reg <= thrust_next;
        end
    end

    // Handshake and result word
    assign item.ready       = (state_reg == S_IDLE);
    assign res_load         = (state_reg == S_DONE) && out_free;
    assign res.thrust       = thrust_reg;
    assign res.prop_flow    = frnd[2*WORD_W-1:WORD_W];
    assign res.firing       = flag_reg;
    assign res.valve_out    = valve_reg;
    assign res.pressure_out = press_reg;

    // Lag states never leave [0, 1]
    a_valve_range: assert property (@(posedge clk) disable iff (!rst_n)
        valve_reg <= Q_ONE)
        else $error("valve position above unity");

    a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
        press_reg <= Q_ONE)
        else $error("pressure fraction above unity");

    // Gain handed to the multiplier is saturated at one
    a_gain_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VMUL || state_reg == S_PMUL) |-> (mul_b <= {7'd0, GAIN_ONE}))
        else $error("lag gain above unity");

    // A fire command clears the off timer
    a_off_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TIMER && cmd_reg) |=> (off_reg == '0))
        else $error("off timer not cleared while firing commanded");

endmodule

// ----- src/thruster_valve_pressure_lag.sv -----
// Thruster valve and pressure lag model, top level.
// Each input word is accepted only while the sequencer is idle; it then runs the
// timer, lag, thrust and flow steps, and six products go in series through one
// shared 32x32 multiplier. A new word waits until the last result is registered.
// Async reset (rst_n low) clears config registers, timers, flag, valve and pressure.
// Depends on tvpl_pkg, tvpl_if, tvpl_cfg, tvpl_mul and tvpl_ctrl.
module thruster_valve_pressure_lag (
    input  logic        clk,
    input  logic        rst_n,
    tvpl_item_if.sink   item,
    tvpl_result_if.source result,
    tvpl_cfg_if.sink    cfg
);
    import tvpl_pkg::*;

    cfg_t  regs;
    res_t  res;
    logic  res_load;
    logic  out_free;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;

    tvpl_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tvpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .regs     (regs),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.thrust       = out_reg.thrust;
    assign result.prop_flow    = out_reg.prop_flow;
    assign result.firing       = out_reg.firing;
    assign result.valve_out    = out_reg.valve_out;
    assign result.pressure_out = out_reg.pressure_out;

endmodule
